@@ rtl/core/bfdh_pkg.sv @@
// shared constants and types for the bloom filter double hash unit
package bfdh_pkg;

   // hash words and store rows
   localparam int HASH_WIDTH = 64;
   localparam int ROW_WIDTH  = 64;
   localparam int ROW_SHIFT  = 6;

   // register fields
   localparam int BIT_COUNT_WIDTH  = 17;
   localparam int HASH_COUNT_WIDTH = 6;
   localparam int CSR_DATA_WIDTH   = 17;
   localparam int COUNT_WIDTH      = 32;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_BIT_COUNT  = 1'b0;
   localparam csr_index_type CSR_HASH_COUNT = 1'b1;

   localparam logic [BIT_COUNT_WIDTH-1:0]  BIT_COUNT_RESET  = 17'd65536;
   localparam logic [HASH_COUNT_WIDTH-1:0] HASH_COUNT_RESET = 6'd7;

   // operation codes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

endpackage

@@ rtl/core/bfdh_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module bfdh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                         write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

@@ rtl/core/bfdh_rem.sv @@
// bit-serial remainders of two 64-bit hashes and of 2^64-1 by a shared modulus
module bfdh_rem #(
   parameter int MAX_BITS = 65536
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [$clog2(MAX_BITS+1)-1:0]         modulus,
   input  logic [bfdh_pkg::HASH_WIDTH-1:0]       dividend_first,
   input  logic [bfdh_pkg::HASH_WIDTH-1:0]       dividend_second,
   output logic                                  done,
   output logic [$clog2(MAX_BITS)-1:0]           rem_first,
   output logic [$clog2(MAX_BITS)-1:0]           rem_second,
   output logic [$clog2(MAX_BITS)-1:0]           rem_wrap
);

   localparam int MW = $clog2(MAX_BITS);
   localparam int CW = $clog2(MAX_BITS + 1);
   localparam int HW = bfdh_pkg::HASH_WIDTH;
   localparam int NW = $clog2(HW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] count_ff, count_in;
   logic [HW-1:0] first_ff, first_in;
   logic [HW-1:0] second_ff, second_in;
   logic [MW-1:0] rem_first_ff, rem_first_in;
   logic [MW-1:0] rem_second_ff, rem_second_in;
   logic [MW-1:0] rem_wrap_ff, rem_wrap_in;
   logic [CW-1:0] modulus_ff, modulus_in;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] rem,
                                              input logic          bit_in,
                                              input logic [CW-1:0] m);
      logic [MW:0] t;
      t = {rem, bit_in};
      if (t >= (MW+1)'(m)) begin
         t = t - (MW+1)'(m);
      end
      return t[MW-1:0];
   endfunction

   always_comb begin
      busy_in       = busy_ff;
      done_in       = 1'b0;
      count_in      = count_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      rem_first_in  = rem_first_ff;
      rem_second_in = rem_second_ff;
      rem_wrap_in   = rem_wrap_ff;
      modulus_in    = modulus_ff;
      if (start) begin
         busy_in       = 1'b1;
         count_in      = '0;
         first_in      = dividend_first;
         second_in     = dividend_second;
         rem_first_in  = '0;
         rem_second_in = '0;
         rem_wrap_in   = '0;
         modulus_in    = modulus;
      end else if (busy_ff) begin
         rem_first_in  = rem_step(rem_first_ff, first_ff[HW-1], modulus_ff);
         rem_second_in = rem_step(rem_second_ff, second_ff[HW-1], modulus_ff);
         // all-ones dividend, so every shifted-in bit is a one
         rem_wrap_in   = rem_step(rem_wrap_ff, 1'b1, modulus_ff);
         first_in      = {first_ff[HW-2:0], 1'b0};
         second_in     = {second_ff[HW-2:0], 1'b0};
         count_in      = count_ff + NW'(1);
         if (count_ff == NW'(HW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      first_ff      <= first_in;
      second_ff     <= second_in;
      rem_first_ff  <= rem_first_in;
      rem_second_ff <= rem_second_in;
      rem_wrap_ff   <= rem_wrap_in;
      modulus_ff    <= modulus_in;
   end

   assign done       = done_ff;
   assign rem_first  = rem_first_ff;
   assign rem_second = rem_second_ff;
   assign rem_wrap   = rem_wrap_ff;

endmodule

@@ rtl/core/bloom_filter_double_hash_unit.sv @@
// bloom filter with double hashing: top level, control sequencer and bit store
//
// One request transfer carries a mode (insert, query, clear), two 64-bit key
// hashes and an empty-key flag; every request gives exactly one response
// transfer with a status, a query answer and the item count after the
// operation. Probe i addresses bit ((hash_first + i*hash_second) mod 2^64) mod m.
// The block reduces both hashes and 2^64 by m once in a bit-serial remainder
// unit (three lanes side by side) and then walks the probes: one add and one
// conditional subtract step the position by hash_second mod m, while a running
// 64-bit sum of the probe addresses flags each wrap at 2^64, and a wrap takes
// 2^64 mod m back off the position. The filter bits live in one ram of 64-bit
// rows (MAX_BITS/64 rows) with a registered read; each probe is a read state
// followed by a check state that, for an insert, writes the row back with the
// probed bit set, so no two accesses to a row ever overlap.
// An insert or query runs the 64-step remainder and then a read and a check
// per probe; a query ends early at the first clear bit. A key flagged empty,
// mode 3 or k = 0 goes straight to the response. A clear sweeps the ram one
// row a cycle over all MAX_BITS/64 rows (1024 at the default size), and the
// same sweep runs right after reset, during which requests are stalled
// (register writes still land).
// Registers may only be written while the block is idle. A finished response
// waits in an output register, so the next request is accepted while it is
// still stalled downstream.
module bloom_filter_double_hash_unit #(
   parameter int MAX_BITS   = 65536,
   parameter int MAX_HASHES = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_mode,
   input  logic [bfdh_pkg::HASH_WIDTH-1:0]         req_hash_first,
   input  logic [bfdh_pkg::HASH_WIDTH-1:0]         req_hash_second,
   input  logic                                    req_key_empty,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_status,
   output logic                                    rsp_present,
   output logic [bfdh_pkg::COUNT_WIDTH-1:0]        rsp_items_held,
   // register write port
   input  logic                                    csr_write_enable,
   input  bfdh_pkg::csr_index_type                 csr_index,
   input  logic [bfdh_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   localparam int MW        = $clog2(MAX_BITS);
   localparam int CW        = $clog2(MAX_BITS + 1);
   localparam int KW        = $clog2(MAX_HASHES + 1);
   localparam int RW        = bfdh_pkg::ROW_WIDTH;
   localparam int ROW_SHIFT = bfdh_pkg::ROW_SHIFT;
   localparam int DEPTH     = (MAX_BITS + RW - 1) / RW;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW        = bfdh_pkg::BIT_COUNT_WIDTH;
   localparam int HCW       = bfdh_pkg::HASH_COUNT_WIDTH;
   localparam int NW        = bfdh_pkg::COUNT_WIDTH;
   localparam int HW        = bfdh_pkg::HASH_WIDTH;

   typedef enum logic [5:0] {
      ST_SWEEP   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_DIVIDE  = 6'b000100,
      ST_READ    = 6'b001000,
      ST_CHECK   = 6'b010000,
      ST_RESPOND = 6'b100000
   } state_type;

   // control state
   state_type      state_ff, state_in;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic           reply_ff, reply_in;
   logic [NW-1:0]  item_count_ff, item_count_in;
   logic [BW-1:0]  bit_count_ff, bit_count_in;
   logic [HCW-1:0] hash_count_ff, hash_count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0]  probe_ff, probe_in;

   // per-item working registers
   logic           insert_ff, insert_in;
   logic           status_ff, status_in;
   logic           present_ff, present_in;
   logic [CW-1:0]  m_ff, m_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [MW-1:0]  r_ff, r_in;
   logic [MW-1:0]  s_ff, s_in;
   logic [MW-1:0]  a_ff, a_in;       // next position before the wrap fix
   logic [MW-1:0]  t_ff, t_in;       // 2^64 mod m
   logic [HW-1:0]  x_ff, x_in;       // running 64-bit probe address
   logic [HW-1:0]  step_ff, step_in;

   // response payload
   logic           rsp_status_ff, rsp_status_in;
   logic           rsp_present_ff, rsp_present_in;
   logic [NW-1:0]  rsp_items_ff, rsp_items_in;

   // effective configuration
   logic [31:0]    bit_count_wide;
   logic [CW-1:0]  m_eff;
   logic [KW-1:0]  k_eff;

   logic           accept;
   logic           div_start;
   logic           rem_done;
   logic [MW-1:0]  rem_first;
   logic [MW-1:0]  rem_second;
   logic [MW-1:0]  rem_wrap;

   // store access
   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [RW-1:0]  ram_wdata;
   logic [AW-1:0]  row_addr;
   logic [RW-1:0]  row_data;
   logic [RW-1:0]  bit_mask;
   logic           probe_hit;
   logic [MW:0]    probe_sum;
   logic [MW-1:0]  r_step;
   logic [MW:0]    wrap_sum;
   logic [MW-1:0]  wrap_mod;
   logic [HW:0]    x_sum;
   logic [MW:0]    a_diff;
   logic [MW-1:0]  r_wrapped;

   // a zero bit count acts as one; m and k clamp to MAX_BITS and MAX_HASHES
   always_comb begin
      bit_count_wide = 32'(bit_count_ff);
      if (bit_count_wide == 32'd0) begin
         m_eff = CW'(1);
      end else if (bit_count_wide > 32'(MAX_BITS)) begin
         m_eff = CW'(MAX_BITS);
      end else begin
         m_eff = CW'(bit_count_ff);
      end
      if (8'(hash_count_ff) > 8'(MAX_HASHES)) begin
         k_eff = KW'(MAX_HASHES);
      end else begin
         k_eff = KW'(hash_count_ff);
      end
   end

   // requests only while idle; the sweep and probe walk own the store
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // next probe position: both terms are already below m
   assign probe_sum = {1'b0, r_ff} + {1'b0, s_ff};
   assign r_step    = (probe_sum >= (MW+1)'(m_ff)) ? MW'(probe_sum - (MW+1)'(m_ff))
                                                    : probe_sum[MW-1:0];

   // 2^64 mod m from (2^64-1) mod m
   assign wrap_sum  = {1'b0, rem_wrap} + (MW+1)'(1);
   assign wrap_mod  = (wrap_sum == (MW+1)'(m_ff)) ? '0 : wrap_sum[MW-1:0];

   // a carry out of the 64-bit address means the position overshot by 2^64 mod m
   assign x_sum     = {1'b0, x_ff} + {1'b0, step_ff};
   assign a_diff    = {1'b0, a_ff} - {1'b0, t_ff};
   assign r_wrapped = a_diff[MW] ? MW'(a_diff + (MW+1)'(m_ff)) : a_diff[MW-1:0];

   assign row_addr  = AW'(r_ff >> ROW_SHIFT);
   assign bit_mask  = RW'(1) << r_ff[ROW_SHIFT-1:0];
   assign probe_hit = row_data[r_ff[ROW_SHIFT-1:0]];

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      reply_in       = reply_ff;
      item_count_in  = item_count_ff;
      bit_count_in   = bit_count_ff;
      hash_count_in  = hash_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      probe_in       = probe_ff;
      insert_in      = insert_ff;
      status_in      = status_ff;
      present_in     = present_ff;
      m_in           = m_ff;
      k_in           = k_ff;
      r_in           = r_ff;
      s_in           = s_ff;
      a_in           = a_ff;
      t_in           = t_ff;
      x_in           = x_ff;
      step_in        = step_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_present_in = rsp_present_ff;
      rsp_items_in   = rsp_items_ff;
      div_start      = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = row_addr;
      ram_wdata      = row_data | bit_mask;

      // register writes
      if (csr_write_enable) begin
         unique case (csr_index)
            bfdh_pkg::CSR_BIT_COUNT:  bit_count_in  = csr_write_data[BW-1:0];
            bfdh_pkg::CSR_HASH_COUNT: hash_count_in = csr_write_data[HCW-1:0];
         endcase
      end

      // response register drains on a transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_SWEEP: begin
            // zero one row a cycle
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == AW'(DEPTH - 1)) begin
               sweep_in = '0;
               state_in = reply_ff ? ST_RESPOND : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               status_in  = 1'b0;
               present_in = 1'b0;
               insert_in  = (req_mode == bfdh_pkg::MODE_INSERT);
               m_in       = m_eff;
               k_in       = k_eff;
               x_in       = req_hash_first;
               step_in    = req_hash_second;
               priority if (req_mode == bfdh_pkg::MODE_CLEAR) begin
                  // empty key does not matter for a clear
                  item_count_in = '0;
                  reply_in      = 1'b1;
                  state_in      = ST_SWEEP;
               end else if (req_mode == bfdh_pkg::MODE_INSERT ||
                            req_mode == bfdh_pkg::MODE_QUERY) begin
                  if (req_key_empty) begin
                     status_in = 1'b1;
                     state_in  = ST_RESPOND;
                  end else begin
                     if (req_mode == bfdh_pkg::MODE_INSERT && item_count_ff != '1) begin
                        item_count_in = item_count_ff + NW'(1);
                     end
                     present_in = (req_mode == bfdh_pkg::MODE_QUERY);
                     if (k_eff == '0) begin
                        state_in = ST_RESPOND;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIVIDE;
                     end
                  end
               end else begin
                  // unused mode: no-op with a plain success
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_DIVIDE: begin
            if (rem_done) begin
               r_in     = rem_first;
               s_in     = rem_second;
               t_in     = wrap_mod;
               probe_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // row address is issued from r_ff this cycle
            a_in     = r_step;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            probe_in = probe_ff + KW'(1);
            x_in     = x_sum[HW-1:0];
            r_in     = x_sum[HW] ? r_wrapped : a_ff;
            if (insert_ff) begin
               ram_we = 1'b1;
            end
            if (!insert_ff && !probe_hit) begin
               // first clear bit settles the query
               present_in = 1'b0;
               state_in   = ST_RESPOND;
            end else if (probe_ff == k_ff - KW'(1)) begin
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_present_in = present_ff;
               rsp_items_in   = item_count_ff;
               reply_in       = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         reply_ff      <= 1'b0;
         item_count_ff <= '0;
         bit_count_ff  <= bfdh_pkg::BIT_COUNT_RESET;
         hash_count_ff <= bfdh_pkg::HASH_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
         probe_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         reply_ff      <= reply_in;
         item_count_ff <= item_count_in;
         bit_count_ff  <= bit_count_in;
         hash_count_ff <= hash_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         probe_ff      <= probe_in;
      end
      insert_ff      <= insert_in;
      status_ff      <= status_in;
      present_ff     <= present_in;
      m_ff           <= m_in;
      k_ff           <= k_in;
      r_ff           <= r_in;
      s_ff           <= s_in;
      a_ff           <= a_in;
      t_ff           <= t_in;
      x_ff           <= x_in;
      step_ff        <= step_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_items_ff   <= rsp_items_in;
   end

   // reduces both hashes and 2^64-1 by the modulus
   bfdh_rem #(
      .MAX_BITS (MAX_BITS)
   ) u_rem (
      .clock           (clock),
      .reset           (reset),
      .start           (div_start),
      .modulus         (m_eff),
      .dividend_first  (req_hash_first),
      .dividend_second (req_hash_second),
      .done            (rem_done),
      .rem_first       (rem_first),
      .rem_second      (rem_second),
      .rem_wrap        (rem_wrap)
   );

   // filter bits, one 64-bit row per entry
   bfdh_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (row_addr),
      .read_data     (row_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_items_held = rsp_items_ff;

   // no store write while waiting for a request
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("store written while idle");

   // remainder result only arrives while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      rem_done |-> (state_ff == ST_DIVIDE))
      else $error("remainder done outside divide state");

   // probe walk stays within k probes and below the modulus
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_CHECK)) |->
         ((probe_ff < k_ff) && (CW'(r_ff) < m_ff)))
      else $error("probe walk out of range");

   // a response only appears from the respond state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESPOND))
      else $error("response raised outside respond state");

endmodule
